/* hw/rtl/pid_pwm_heater_controller_assert.svh */
// Assertion macros for the heater controller.
// PPHC_ASSERT checks a property at every rising clock edge outside reset.
// PPHC_ASSERT_NEXT checks that a condition implies a property in the next cycle.
`ifndef PID_PWM_HEATER_CONTROLLER_ASSERT_SVH
`define PID_PWM_HEATER_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define PPHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PPHC_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define PPHC_ASSERT(lbl, clk, rstn, prop, msg)
`define PPHC_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif

`endif

/* hw/rtl/pphc_pkg.sv */
package pphc_pkg;

    // Fixed field widths
    localparam int MEAS_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 10;
    localparam int FRAC_W   = 8;
    localparam int INTEG_W  = DUTY_W + FRAC_W;
    localparam int CNT_W    = 16;
    localparam int ADDR_W   = 5;

    typedef logic [2:0] reg_idx_t;
    typedef logic [1:0] status_t;

    // Register map, word index
    localparam reg_idx_t REG_SETPOINT    = 3'd0;
    localparam reg_idx_t REG_KP_GAIN     = 3'd1;
    localparam reg_idx_t REG_KI_GAIN     = 3'd2;
    localparam reg_idx_t REG_KD_GAIN     = 3'd3;
    localparam reg_idx_t REG_MIN_OUT     = 3'd4;
    localparam reg_idx_t REG_MAX_OUT     = 3'd5;
    localparam reg_idx_t REG_STALL_LIMIT = 3'd6;

    // Result status codes
    localparam status_t STATUS_NORMAL  = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_STALL   = 2'd2;

endpackage

/* hw/rtl/pid_pwm_heater_controller.sv */
// Each input transfer passes through the input register and then the result register.
// Throughput: one item per cycle unless m_tready stalls; the loop update (three 16x17
// products, sum, two clamps) completes in the single stage between input and result
// registers. Reset: synchronous, active low; gains, limits and loop state return to
// their defaults, both channels empty.
`include "pid_pwm_heater_controller_assert.svh"

module pid_pwm_heater_controller #(
    parameter int PWM_BITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pphc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] measurement
    input  logic [0:0]                   s_tuser,   // [0] sample_valid
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [9:0] drive_duty, [15:10] zero
    output logic [1:0]                   m_tuser    // [1:0] status
);

    import pphc_pkg::*;

    // Full scale of the PWM counter, used by the ten percent test and max_out reset.
    localparam logic [16:0] FULL_SCALE = 17'((1 << PWM_BITS) - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [MEAS_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0]        kp_gain_reg;
    logic [GAIN_W-1:0]        ki_gain_reg;
    logic [GAIN_W-1:0]        kd_gain_reg;
    logic [DUTY_W-1:0]        min_out_reg;
    logic [DUTY_W-1:0]        max_out_reg;
    logic [CNT_W-1:0]         stall_limit_reg;

    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg    <= '0;
            kp_gain_reg     <= 16'd256;
            ki_gain_reg     <= '0;
            kd_gain_reg     <= '0;
            min_out_reg     <= '0;
            max_out_reg     <= FULL_SCALE[DUTY_W-1:0];
            stall_limit_reg <= 16'd100;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SETPOINT:    setpoint_reg    <= pwdata[MEAS_W-1:0];
                REG_KP_GAIN:     kp_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_KI_GAIN:     ki_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_KD_GAIN:     kd_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_MIN_OUT:     min_out_reg     <= pwdata[DUTY_W-1:0];
                REG_MAX_OUT:     max_out_reg     <= pwdata[DUTY_W-1:0];
                REG_STALL_LIMIT: stall_limit_reg <= pwdata[CNT_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    // Read back; values are zero extended.
    always_comb begin
        unique case (cfg_idx)
            REG_SETPOINT:    prdata = {16'd0, setpoint_reg};
            REG_KP_GAIN:     prdata = {16'd0, kp_gain_reg};
            REG_KI_GAIN:     prdata = {16'd0, ki_gain_reg};
            REG_KD_GAIN:     prdata = {16'd0, kd_gain_reg};
            REG_MIN_OUT:     prdata = {22'd0, min_out_reg};
            REG_MAX_OUT:     prdata = {22'd0, max_out_reg};
            REG_STALL_LIMIT: prdata = {16'd0, stall_limit_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register -> compute -> result register
    // ------------------------------------------------------------------
    logic                     in_vld_reg;
    logic signed [MEAS_W-1:0] in_meas_reg;
    logic                     in_ok_reg;
    logic                     out_vld_reg;
    logic [DUTY_W-1:0]        out_duty_reg;
    status_t                  out_status_reg;

    logic advance;   // result register can take a new value this cycle
    logic process;   // held item is computed and, if valid, its state update committed

    assign advance  = !out_vld_reg || m_tready;
    assign process  = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    // Capture payload on each transfer.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_meas_reg <= s_tdata;
            in_ok_reg   <= s_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // Loop state
    // ------------------------------------------------------------------
    logic signed [MEAS_W-1:0] prev_meas_reg;
    logic [INTEG_W-1:0]       integ_reg;
    logic [CNT_W-1:0]         count_reg;

    logic [INTEG_W-1:0] integ_next;
    logic [CNT_W-1:0]   count_next;

    // ------------------------------------------------------------------
    // Datapath: derivative and proportional action taken on measurement
    // ------------------------------------------------------------------
    logic signed [16:0] delta_val;
    logic signed [16:0] err_val;
    logic signed [33:0] ki_prod;
    logic signed [33:0] kp_prod;
    logic signed [33:0] kd_prod;
    logic signed [34:0] acc_val;
    logic signed [34:0] res_val;
    logic signed [34:0] lo_lim;
    logic signed [34:0] hi_lim;
    logic [INTEG_W-1:0] res_clamp;
    logic [DUTY_W-1:0]  duty_val;
    logic [13:0]        duty_x10;
    logic               stall;

    assign delta_val = {in_meas_reg[MEAS_W-1], in_meas_reg}
                     - {prev_meas_reg[MEAS_W-1], prev_meas_reg};
    assign err_val   = {setpoint_reg[MEAS_W-1], setpoint_reg}
                     - {in_meas_reg[MEAS_W-1], in_meas_reg};

    assign ki_prod = $signed({1'b0, ki_gain_reg}) * err_val;
    assign kp_prod = $signed({1'b0, kp_gain_reg}) * delta_val;
    assign kd_prod = $signed({1'b0, kd_gain_reg}) * delta_val;

    assign lo_lim = $signed({17'd0, min_out_reg, 8'd0});
    assign hi_lim = $signed({17'd0, max_out_reg, 8'd0});

    // Integrator: add ki*error, remove kp*delta, clamp high limit first.
    assign acc_val = $signed({17'd0, integ_reg}) + 35'(ki_prod) - 35'(kp_prod);

    always_comb begin
        if (acc_val > hi_lim) begin
            integ_next = {max_out_reg, 8'd0};
        end else if (acc_val < lo_lim) begin
            integ_next = {min_out_reg, 8'd0};
        end else begin
            integ_next = acc_val[INTEG_W-1:0];
        end
    end

    // Output: integrator minus kd*delta, same clamp.
    assign res_val = $signed({17'd0, integ_next}) - 35'(kd_prod);

    always_comb begin
        if (res_val > hi_lim) begin
            res_clamp = {max_out_reg, 8'd0};
        end else if (res_val < lo_lim) begin
            res_clamp = {min_out_reg, 8'd0};
        end else begin
            res_clamp = res_val[INTEG_W-1:0];
        end
    end

    assign duty_val = res_clamp[INTEG_W-1:FRAC_W];

    // Saturating count of samples without a measurement change.
    always_comb begin
        if (delta_val != 17'sd0) begin
            count_next = '0;
        end else if (count_reg == {CNT_W{1'b1}}) begin
            count_next = count_reg;
        end else begin
            count_next = count_reg + 1'b1;
        end
    end

    // Exact ten percent test: duty*10 > full scale.
    assign duty_x10 = {1'b0, duty_val, 3'd0} + {3'd0, duty_val, 1'b0};
    assign stall    = ({3'd0, duty_x10} > FULL_SCALE) && (count_next > stall_limit_reg);

    // Commit loop state only for a valid sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_meas_reg <= '0;
            integ_reg     <= '0;
            count_reg     <= '0;
        end else if (process && in_ok_reg) begin
            prev_meas_reg <= in_meas_reg;
            integ_reg     <= integ_next;
            count_reg     <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            if (!in_ok_reg) begin
                out_duty_reg   <= min_out_reg;
                out_status_reg <= STATUS_INVALID;
            end else if (stall) begin
                out_duty_reg   <= min_out_reg;
                out_status_reg <= STATUS_STALL;
            end else begin
                out_duty_reg   <= duty_val;
                out_status_reg <= STATUS_NORMAL;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_duty_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PPHC_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tuser != 2'd3), "bad status code")
    `PPHC_ASSERT(a_forced_off, aclk, aresetn, (m_tvalid && (m_tuser == STATUS_INVALID || m_tuser == STATUS_STALL)) |-> (m_tdata[DUTY_W-1:0] == min_out_reg), "forced-off result not at min_out")
    `PPHC_ASSERT_NEXT(a_invalid_hold, aclk, aresetn, process && !in_ok_reg, $stable(integ_reg) && $stable(prev_meas_reg) && $stable(count_reg), "invalid sample changed loop state")
    `PPHC_ASSERT(a_stall_ready, aclk, aresetn, !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready), "input stalled without backpressure")

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import pphc_pkg::*;

    localparam int     PWM_BITS    = 10;
    localparam longint FULL_SCALE  = (longint'(1) << PWM_BITS) - 1;
    localparam int     HOLD_CYCLES = 240;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 206;

    // One sensor sample as it travels on the s_ side.
    typedef struct packed {
        logic signed [MEAS_W-1:0] meas;
        logic                     ok;
    } sample_t;

    // One predicted drive result.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        status_t           flag;
    } drive_t;

    // Clock, reset and all block inputs start at known values.
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // [15:0] measurement
    logic [0:0]        s_tuser  = '0;   // [0] sample_valid
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // [9:0] drive_duty, [15:10] zero
    logic [1:0]        m_tuser;         // [1:0] status

    // Shadow copy of the loop registers, reset values.
    logic signed [MEAS_W-1:0] heater_setpoint = '0;
    logic [GAIN_W-1:0]        gain_p          = 16'd256;
    logic [GAIN_W-1:0]        gain_i          = '0;
    logic [GAIN_W-1:0]        gain_d          = '0;
    logic [DUTY_W-1:0]        duty_floor      = '0;
    logic [DUTY_W-1:0]        duty_ceiling    = DUTY_W'(FULL_SCALE);
    logic [CNT_W-1:0]         stall_cfg       = 16'd100;

    // Predicted loop state.
    logic signed [MEAS_W-1:0] last_meas  = '0;
    longint                   integ_acc  = 0;
    logic [CNT_W-1:0]         flat_count = '0;

    sample_t     staged_q[$];      // built by the stimulus, released in one go
    sample_t     pending_q[$];     // waiting for the driver
    drive_t      duty_expect_q[$]; // predicted results not yet seen
    sample_t     next_item;
    int unsigned queued_count    = 0;
    int unsigned fed_count       = 0;
    int unsigned miss_count      = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;
    logic        s_took          = 1'b0;
    logic        sink_hold       = 1'b0;
    logic        hold_go         = 1'b0;

    pid_pwm_heater_controller #(
        .PWM_BITS(PWM_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Clamp with the high limit tested first, so inverted limits land on
    // max_out above it and on min_out everywhere else.
    function automatic longint clamp_high_first(longint v, longint lo, longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Advance the heater loop by one sample and return the drive it produces.
    function automatic drive_t heater_step(logic signed [MEAS_W-1:0] meas, logic ok);
        drive_t d;
        longint lo;
        longint hi;
        longint delta;
        longint err;
        longint res;
        // An unreadable sample forces the floor and leaves the loop untouched.
        if (!ok) begin
            d.duty = duty_floor;
            d.flag = STATUS_INVALID;
            return d;
        end
        lo        = longint'(duty_floor) << FRAC_W;
        hi        = longint'(duty_ceiling) << FRAC_W;
        delta     = longint'(meas) - longint'(last_meas);
        err       = longint'(heater_setpoint) - longint'(meas);
        last_meas = meas;
        // Integral on error, proportional on measurement change.
        integ_acc = clamp_high_first(integ_acc + longint'(gain_i) * err
                                     - longint'(gain_p) * delta, lo, hi);
        // Derivative on measurement change, then drop the fraction bits.
        res    = clamp_high_first(integ_acc - longint'(gain_d) * delta, lo, hi);
        d.duty = DUTY_W'(res >>> FRAC_W);
        d.flag = STATUS_NORMAL;
        // Count samples since the reading last moved; saturate at all ones.
        if (delta != 0) begin
            flat_count = '0;
        end else if (flat_count != '1) begin
            flat_count = flat_count + 1'b1;
        end
        // A stuck sensor with the heater above ten percent trips the stall cutoff.
        if (longint'(d.duty) * 10 > FULL_SCALE && flat_count > stall_cfg) begin
            d.duty = duty_floor;
            d.flag = STATUS_STALL;
        end
        return d;
    endfunction

    task automatic note_miss(string what, int unsigned want, int unsigned got);
        miss_count++;
        if (miss_count <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Input driver: offer the next sample at the falling edge once the current
    // one has been taken, idling at random as the current phase asks.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_item = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.meas;
                s_tuser  <= next_item.ok;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: stall at random, and hold off entirely during the long hold.
    always @(negedge aclk) begin
        m_tready <= aresetn && !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: predict on every input transfer, check every result transfer
    // against the oldest prediction.
    always @(posedge aclk) begin
        s_took = aresetn && s_tvalid && s_tready;
        if (s_took) begin
            duty_expect_q.push_back(heater_step(s_tdata, s_tuser[0]));
            fed_count++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_expect_q.size() == 0) begin
                note_miss("unexpected result, duty", 0, m_tdata[DUTY_W-1:0]);
            end else begin
                if (m_tdata[DUTY_W-1:0] != duty_expect_q[0].duty) begin
                    note_miss("drive_duty", duty_expect_q[0].duty, m_tdata[DUTY_W-1:0]);
                end
                if (m_tuser != duty_expect_q[0].flag) begin
                    note_miss("status", duty_expect_q[0].flag, m_tuser);
                end
                void'(duty_expect_q.pop_front());
            end
            if (m_tdata[15:DUTY_W] != '0) begin
                note_miss("tdata padding", 0, m_tdata[15:DUTY_W]);
            end
        end
    end

    // Long hold-off on the result side while the sender keeps offering, so
    // the block backs up and drops s_tready.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold = 1'b0;
    end

    // APB write: setup cycle, access cycle, then mirror the value in the shadow.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_SETPOINT:    heater_setpoint = value[MEAS_W-1:0];
            REG_KP_GAIN:     gain_p          = value[GAIN_W-1:0];
            REG_KI_GAIN:     gain_i          = value[GAIN_W-1:0];
            REG_KD_GAIN:     gain_d          = value[GAIN_W-1:0];
            REG_MIN_OUT:     duty_floor      = value[DUTY_W-1:0];
            REG_MAX_OUT:     duty_ceiling    = value[DUTY_W-1:0];
            REG_STALL_LIMIT: stall_cfg       = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_loop(logic [15:0] sp, logic [15:0] kp, logic [15:0] ki,
                            logic [15:0] kd, logic [9:0] lo, logic [9:0] hi,
                            logic [15:0] stall);
        write_reg(REG_SETPOINT, 32'(sp));
        write_reg(REG_KP_GAIN, 32'(kp));
        write_reg(REG_KI_GAIN, 32'(ki));
        write_reg(REG_KD_GAIN, 32'(kd));
        write_reg(REG_MIN_OUT, 32'(lo));
        write_reg(REG_MAX_OUT, 32'(hi));
        write_reg(REG_STALL_LIMIT, 32'(stall));
    endtask

    task automatic stage(logic [15:0] meas, logic ok);
        sample_t it;
        it.meas = meas;
        it.ok   = ok;
        staged_q.push_back(it);
    endtask

    // Release the staged samples at a rising edge, then wait until every one
    // has been taken and every result has come back.
    task automatic send_and_drain();
        @(posedge aclk);
        while (staged_q.size() != 0) begin
            pending_q.push_back(staged_q.pop_front());
            queued_count++;
        end
        @(negedge aclk);
        while (fed_count != queued_count || duty_expect_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_gain();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) begin
            return 16'h0000;
        end
        if (r < 25) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 768));
    endfunction

    // Stimulus: directed corners, then random phases over the idling modes.
    initial begin
        logic signed [15:0] walk;
        logic [15:0]        sp;
        logic [15:0]        stall;
        logic [9:0]         lo;
        logic [9:0]         hi;
        int unsigned        r;
        int unsigned        run;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Reset values: extremes of the measurement, an unreadable sample.
        stage(16'h8000, 1'b1);
        stage(16'h7FFF, 1'b1);
        stage(16'h7FFF, 1'b1);
        stage(16'h5A5A, 1'b0);
        stage(16'hFFFF, 1'b1);
        stage(16'h0000, 1'b1);
        send_and_drain();

        // Full integral gain and a short stall limit: drive saturates, then
        // the flat reading trips the stall cutoff; a step clears it.
        set_loop(16'd1000, 16'h0000, 16'hFFFF, 16'hFFFF, 10'd0, 10'd1023, 16'd3);
        repeat (6) stage(16'h0000, 1'b1);
        stage(16'd500, 1'b1);
        stage(16'h8000, 1'b0);
        stage(16'd500, 1'b1);
        send_and_drain();

        // Inverted limits and a zero stall limit.
        set_loop(16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 10'd600, 10'd200, 16'd0);
        stage(16'd1000, 1'b1);
        stage(16'd900, 1'b1);
        stage(16'd900, 1'b1);
        stage(16'h8000, 1'b1);
        send_and_drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin sender_idle_pct = 7; sink_stall_pct = 7; end
            endcase

            // Pick loop settings; two phases pin every register to an extreme.
            if (ph == 6) begin
                set_loop(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd0, 16'hFFFF);
            end else if (ph == 7) begin
                set_loop(16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 10'd0, 10'd1023, 16'd0);
            end else begin
                r     = $urandom_range(99);
                sp    = (r < 20) ? 16'($urandom_range(16'hFFFF))
                                 : 16'($urandom_range(0, 4000) - 2000);
                r     = $urandom_range(99);
                lo    = (r < 50) ? 10'd0 : (r < 58) ? 10'd1023 : 10'($urandom_range(0, 300));
                r     = $urandom_range(99);
                hi    = (r < 50) ? 10'd1023 : (r < 58) ? 10'd0 : 10'($urandom_range(200, 1023));
                r     = $urandom_range(99);
                stall = (r < 10) ? 16'd0 : (r < 18) ? 16'hFFFF
                                 : 16'($urandom_range(1, 24));
                set_loop(sp, pick_gain(), pick_gain(), pick_gain(), lo, hi, stall);
            end

            // Mostly a slow random walk around the setpoint with flat runs;
            // the rest is wild readings, extremes and unreadable samples.
            walk = heater_setpoint;
            while (staged_q.size() < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    stage(16'($urandom_range(16'hFFFF)), 1'b0);
                end else if (r < 14) begin
                    walk = 16'($urandom_range(16'hFFFF));
                    stage(walk, 1'b1);
                end else if (r < 18) begin
                    case ($urandom_range(3))
                        0: walk = 16'h8000;
                        1: walk = 16'h7FFF;
                        2: walk = 16'h0000;
                        default: walk = 16'hFFFF;
                    endcase
                    stage(walk, 1'b1);
                end else if (r < 40) begin
                    run = $urandom_range(1, 30);
                    repeat (run) stage(walk, 1'b1);
                end else begin
                    walk = walk + 16'($urandom_range(0, 64)) - 16'd32;
                    stage(walk, 1'b1);
                end
            end

            if (ph == 0) begin
                hold_go = 1'b1;
            end
            send_and_drain();
        end

        repeat (8) @(negedge aclk);
        if (miss_count == 0 && duty_expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule
